// ----- rtl/dmc_pkg.sv -----
package dmc_pkg;

    // Default geometry
    localparam int DEF_LINE_BYTES = 16;
    localparam int DEF_NUM_LINES  = 64;
    localparam int DEF_ADDR_WIDTH = 32;

    // Fixed field widths
    localparam int ADDR_BITS = 32;
    localparam int DATA_BITS = 32;

    // Input command codes
    localparam logic CMD_READ = 1'b0;
    localparam logic CMD_FILL = 1'b1;

    // Result kind codes
    localparam logic KIND_ANSWER   = 1'b0;
    localparam logic KIND_FILL_REQ = 1'b1;

    // Access size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_BAD  = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_ANSWER
    } state_t;

endpackage

// ----- rtl/dmc_ram.sv -----
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/direct_mapped_cache_read_top.sv -----
// Channel  Handshake            Payload
// -------  -------------------  ----------------------------------------------
// in       in_valid / in_stall  command, address, xfer_size, fill_byte
// out      out_valid/out_stall  kind, hit, read_data, fill_address, error
//
// For a read item the tag and data memories are read in the accept cycle
// and the registered data is compared and selected in the next. A refill
// byte is taken in ST_IDLE; the last byte of a line writes the line, then
// the answer comes from the line buffer. Results leave through an output
// register, so the block takes the next item while a result waits there.
// After reset a clearing pass writes every tag entry invalid, one entry per
// cycle, with in_stall high.
module direct_mapped_cache_read_top
    import dmc_pkg::*;
#(
    parameter int LINE_BYTES = DEF_LINE_BYTES,
    parameter int NUM_LINES  = DEF_NUM_LINES,
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic [ADDR_BITS-1:0]        address,
    input  logic [1:0]                  xfer_size,
    input  logic [7:0]                  fill_byte,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic                        hit,
    output logic signed [DATA_BITS-1:0] read_data,
    output logic [ADDR_BITS-1:0]        fill_address,
    output logic                        error
);

    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int IDX_W  = $clog2(NUM_LINES);
    localparam int TAG_SH = OFF_W + IDX_W;
    localparam int TAG_W  = (ADDR_WIDTH > TAG_SH) ? (ADDR_WIDTH - TAG_SH) : 1;
    localparam int ROW_W  = LINE_BYTES * 8;
    localparam int TMEM_W = TAG_W + 1;
    localparam int SUM_W  = OFF_W + 4;

    localparam logic [ADDR_BITS-1:0] ADDR_MASK = ADDR_BITS'({ADDR_WIDTH{1'b1}});

    // ---------------------------------------------------------------
    // State and registers
    // ---------------------------------------------------------------
    state_t state_reg, state_next;

    logic [IDX_W-1:0]     clr_idx_reg, clr_idx_next;
    logic                 fill_pending_reg, fill_pending_next;
    logic [OFF_W-1:0]     fill_cnt_reg, fill_cnt_next;

    // Lookup stage payload
    logic                 lk_err_reg;
    logic [TAG_W-1:0]     lk_tag_reg;
    logic [OFF_W-1:0]     lk_off_reg;
    logic [1:0]           lk_size_reg;
    logic [ADDR_BITS-1:0] lk_addr_reg;

    // Pending miss
    logic [ADDR_BITS-1:0] pend_addr_reg;
    logic [1:0]           pend_size_reg;
    logic [ROW_W-1:0]     line_buf_reg, line_buf_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic                 kind_reg, hit_reg, error_reg;
    logic [DATA_BITS-1:0] read_data_reg;
    logic [ADDR_BITS-1:0] fill_address_reg;

    // ---------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------
    logic [ADDR_BITS-1:0] addr_m;
    logic [OFF_W-1:0]     in_off;
    logic [IDX_W-1:0]     in_idx;
    logic [TAG_W-1:0]     in_tag;
    logic [3:0]           acc_len;
    logic [SUM_W-1:0]     acc_end;
    logic                 early_err;
    logic                 accept, rd_accept, fb_accept, last_beat;

    assign addr_m  = address & ADDR_MASK;
    assign in_off  = addr_m[OFF_W-1:0];
    assign in_idx  = IDX_W'(addr_m >> OFF_W);
    assign in_tag  = TAG_W'(addr_m >> TAG_SH);
    assign acc_len = 4'd1 << xfer_size;
    assign acc_end = SUM_W'(in_off) + SUM_W'(acc_len);

    // Refuse a read during a refill, a bad size, or one that runs off the line
    assign early_err = fill_pending_reg || (xfer_size == SIZE_BAD)
                       || (acc_end > SUM_W'(LINE_BYTES));

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign rd_accept = accept && (command == CMD_READ);
    assign fb_accept = accept && (command == CMD_FILL) && fill_pending_reg;
    assign last_beat = fb_accept && (fill_cnt_reg == OFF_W'(LINE_BYTES - 1));

    // Shift refill bytes in from the top; byte 0 ends at the bottom
    assign line_buf_next = {fill_byte, line_buf_reg[ROW_W-1:8]};

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    logic [IDX_W-1:0]  pend_idx;
    logic [TAG_W-1:0]  pend_tag;
    logic [OFF_W-1:0]  pend_off;
    logic              clear_we;
    logic              tag_we;
    logic [IDX_W-1:0]  tag_waddr;
    logic [TMEM_W-1:0] tag_wdata, tag_rdata;
    logic [ROW_W-1:0]  data_rdata;

    assign pend_idx = IDX_W'(pend_addr_reg >> OFF_W);
    assign pend_tag = TAG_W'(pend_addr_reg >> TAG_SH);
    assign pend_off = pend_addr_reg[OFF_W-1:0];

    assign tag_we    = clear_we || last_beat;
    assign tag_waddr = clear_we ? clr_idx_reg : pend_idx;
    assign tag_wdata = clear_we ? '0 : {1'b1, pend_tag};

    dmc_ram #(
        .WIDTH (TMEM_W),
        .DEPTH (NUM_LINES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (rd_accept),
        .raddr (in_idx),
        .rdata (tag_rdata)
    );

    dmc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_LINES)
    ) u_data_ram (
        .clk   (clk),
        .we    (last_beat),
        .waddr (pend_idx),
        .wdata (line_buf_next),
        .re    (rd_accept),
        .raddr (in_idx),
        .rdata (data_rdata)
    );

    // ---------------------------------------------------------------
    // Hit check and byte select (one shifter for hits and refill answers)
    // ---------------------------------------------------------------
    logic                 tag_hit;
    logic [ROW_W-1:0]     sel_row, sel_shift;
    logic [OFF_W-1:0]     sel_off;
    logic [1:0]           sel_size;
    logic [DATA_BITS-1:0] sel_raw, sel_word;

    assign tag_hit = tag_rdata[TAG_W] && (tag_rdata[TAG_W-1:0] == lk_tag_reg);

    assign sel_row   = (state_reg == ST_ANSWER) ? line_buf_reg : data_rdata;
    assign sel_off   = (state_reg == ST_ANSWER) ? pend_off : lk_off_reg;
    assign sel_size  = (state_reg == ST_ANSWER) ? pend_size_reg : lk_size_reg;
    assign sel_shift = sel_row >> {sel_off, 3'b000};
    assign sel_raw   = sel_shift[DATA_BITS-1:0];

    // Zero-extend byte and halfword reads
    always_comb
    begin
        unique case (sel_size)
            SIZE_BYTE: sel_word = {24'd0, sel_raw[7:0]};
            SIZE_HALF: sel_word = {16'd0, sel_raw[15:0]};
            default:   sel_word = sel_raw;
        endcase
    end

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    logic                 out_free;
    logic                 out_load;
    logic                 start_fill;
    logic                 res_kind, res_hit, res_err;
    logic [DATA_BITS-1:0] res_data;
    logic [ADDR_BITS-1:0] res_faddr;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        clear_we   = 1'b0;
        out_load   = 1'b0;
        start_fill = 1'b0;
        res_kind   = KIND_ANSWER;
        res_hit    = 1'b0;
        res_err    = 1'b0;
        res_data   = '0;
        res_faddr  = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_we = 1'b1;
                if (clr_idx_reg == IDX_W'(NUM_LINES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (rd_accept)
                begin
                    state_next = ST_LOOKUP;
                end
                else if (last_beat)
                begin
                    state_next = ST_ANSWER;
                end
            end
            ST_LOOKUP:
            begin
                // Hold until the output register can take the result
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (lk_err_reg)
                    begin
                        res_err = 1'b1;
                    end
                    else if (tag_hit)
                    begin
                        res_hit  = 1'b1;
                        res_data = sel_word;
                    end
                    else
                    begin
                        res_kind   = KIND_FILL_REQ;
                        res_faddr  = {lk_addr_reg[ADDR_BITS-1:OFF_W], {OFF_W{1'b0}}};
                        start_fill = 1'b1;
                    end
                end
            end
            ST_ANSWER:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    res_data   = sel_word;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        clr_idx_next      = clear_we ? clr_idx_reg + 1'b1 : clr_idx_reg;
        fill_pending_next = fill_pending_reg;
        fill_cnt_next     = fill_cnt_reg;
        if (start_fill)
        begin
            fill_pending_next = 1'b1;
            fill_cnt_next     = '0;
        end
        else if (fb_accept)
        begin
            fill_cnt_next = fill_cnt_reg + 1'b1;
            if (last_beat)
            begin
                fill_pending_next = 1'b0;
            end
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_idx_reg      <= '0;
            fill_pending_reg <= 1'b0;
            fill_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_idx_reg      <= clr_idx_next;
            fill_pending_reg <= fill_pending_next;
            fill_cnt_reg     <= fill_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rd_accept)
        begin
            lk_err_reg  <= early_err;
            lk_tag_reg  <= in_tag;
            lk_off_reg  <= in_off;
            lk_size_reg <= xfer_size;
            lk_addr_reg <= addr_m;
        end
        if (start_fill)
        begin
            pend_addr_reg <= lk_addr_reg;
            pend_size_reg <= lk_size_reg;
        end
        if (fb_accept)
        begin
            line_buf_reg <= line_buf_next;
        end
        if (out_load)
        begin
            kind_reg         <= res_kind;
            hit_reg          <= res_hit;
            read_data_reg    <= res_data;
            fill_address_reg <= res_faddr;
            error_reg        <= res_err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign hit          = hit_reg;
    assign read_data    = $signed(read_data_reg);
    assign fill_address = fill_address_reg;
    assign error        = error_reg;

endmodule

// ----- rtl/dmc_checker.sv -----
module dmc_checker
    import dmc_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        kind,
    input logic                        hit,
    input logic signed [DATA_BITS-1:0] read_data,
    input logic [ADDR_BITS-1:0]        fill_address,
    input logic                        error
);

    a_fill_req_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_FILL_REQ) |-> (read_data == 0 && !hit && !error))
        else $error("fill request carries read data, hit or error");

    a_answer_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_ANSWER) |-> (fill_address == 0))
        else $error("read answer carries a fill address");

    a_error_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> (!hit && read_data == 0))
        else $error("refused read reports hit or data");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(hit)
            && $stable(read_data) && $stable(fill_address) && $stable(error)))
        else $error("stalled result changed");

endmodule

bind direct_mapped_cache_read_top dmc_checker u_dmc_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import dmc_pkg::*;

    // Cache geometry as built; the address splits into tag | index | offset
    localparam int LINE_BYTES = DEF_LINE_BYTES;
    localparam int NUM_LINES  = DEF_NUM_LINES;
    localparam int OFF_BITS   = $clog2(LINE_BYTES);
    localparam int IDX_BITS   = $clog2(NUM_LINES);
    localparam int TAG_BITS   = ADDR_BITS - OFF_BITS - IDX_BITS;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int TAIL_CYCLES  = 20;
    // Cycles without any handshake on either side before the run is abandoned.
    // The clearing pass after reset and the random stalls are short.
    localparam int QUIET_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic                 cmd;
        logic [ADDR_BITS-1:0] addr;
        logic [1:0]           size;
        logic [7:0]           fbyte;
    } access_t;

    typedef struct {
        logic                 kind;
        logic                 hit;
        logic [DATA_BITS-1:0] data;
        logic [ADDR_BITS-1:0] faddr;
        logic                 err;
    } cache_reply_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic                        in_stall;
    logic                        command      = CMD_READ;
    logic [ADDR_BITS-1:0]        address      = '0;
    logic [1:0]                  xfer_size    = SIZE_BYTE;
    logic [7:0]                  fill_byte    = '0;
    logic                        out_valid;
    logic                        out_stall    = 1'b0;
    logic                        kind;
    logic                        hit;
    logic signed [DATA_BITS-1:0] read_data;
    logic [ADDR_BITS-1:0]        fill_address;
    logic                        error;

    direct_mapped_cache_read_top #(
        .LINE_BYTES (LINE_BYTES),
        .NUM_LINES  (NUM_LINES),
        .ADDR_WIDTH (DEF_ADDR_WIDTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .address      (address),
        .xfer_size    (xfer_size),
        .fill_byte    (fill_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .hit          (hit),
        .read_data    (read_data),
        .fill_address (fill_address),
        .error        (error)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Items waiting to be driven, and results the cache owes us, oldest first
    access_t      access_q[$];
    cache_reply_t cache_replies[$];

    // Idle/stall odds in percent for the current phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatches = 0;
    int n_queued   = 0;
    int n_reads    = 0;
    int n_hits     = 0;
    int n_misses   = 0;
    int n_refused  = 0;
    int n_refills  = 0;
    int n_fill_in  = 0;
    int quiet      = 0;

    // ------------------------------------------------------------------
    // Cache shadow, advanced once per accepted item
    // ------------------------------------------------------------------
    bit                   line_ok   [NUM_LINES];
    logic [TAG_BITS-1:0]  line_tag  [NUM_LINES];
    logic [7:0]           line_mem  [NUM_LINES * LINE_BYTES];
    bit                   fill_pending = 1'b0;
    logic [ADDR_BITS-1:0] pend_addr    = '0;
    logic [1:0]           pend_size    = SIZE_BYTE;
    int                   fill_count   = 0;

    // Gather 1, 2 or 4 bytes little-endian from a stored line; zero-extend
    function automatic logic [DATA_BITS-1:0] line_word(int idx, int off, logic [1:0] size);
        logic [DATA_BITS-1:0] v;
        v = '0;
        for (int i = 0; i < (1 << size); i++)
            v |= DATA_BITS'(line_mem[idx * LINE_BYTES + off + i]) << (8 * i);
        return v;
    endfunction

    task automatic cache_step(input access_t a);
        cache_reply_t        r;
        int                  off;
        int                  idx;
        logic [TAG_BITS-1:0] tg;
        r.kind  = KIND_ANSWER;
        r.hit   = 1'b0;
        r.data  = '0;
        r.faddr = '0;
        r.err   = 1'b0;
        if (a.cmd == CMD_READ)
        begin
            n_reads++;
            off = int'(a.addr[OFF_BITS-1:0]);
            idx = int'(a.addr[OFF_BITS +: IDX_BITS]);
            tg  = a.addr[ADDR_BITS-1 -: TAG_BITS];
            // Refuse: fill still outstanding, bad size, or access past line end
            if (fill_pending || a.size == SIZE_BAD || off + (1 << a.size) > LINE_BYTES)
            begin
                r.err = 1'b1;
                n_refused++;
            end
            else if (line_ok[idx] && line_tag[idx] == tg)
            begin
                r.hit  = 1'b1;
                r.data = line_word(idx, off, a.size);
                n_hits++;
            end
            else
            begin
                fill_pending = 1'b1;
                pend_addr    = a.addr;
                pend_size    = a.size;
                fill_count   = 0;
                r.kind       = KIND_FILL_REQ;
                r.faddr      = {a.addr[ADDR_BITS-1:OFF_BITS], OFF_BITS'(0)};
                n_misses++;
            end
            cache_replies.insert(cache_replies.size(), r);
        end
        else if (fill_pending)
        begin
            // Refill bytes arrive in ascending order; the last one answers the read
            n_fill_in++;
            idx = int'(pend_addr[OFF_BITS +: IDX_BITS]);
            line_mem[idx * LINE_BYTES + fill_count] = a.fbyte;
            fill_count++;
            if (fill_count == LINE_BYTES)
            begin
                line_tag[idx] = pend_addr[ADDR_BITS-1 -: TAG_BITS];
                line_ok[idx]  = 1'b1;
                fill_pending  = 1'b0;
                fill_count    = 0;
                r.data        = line_word(idx, int'(pend_addr[OFF_BITS-1:0]), pend_size);
                cache_replies.insert(cache_replies.size(), r);
                n_refills++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: hold the item until taken, then pull the next one or idle
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        access_t cur;
        access_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                cur.cmd   = command;
                cur.addr  = address;
                cur.size  = xfer_size;
                cur.fbyte = fill_byte;
                cache_step(cur);
            end
            if (access_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = access_q.pop_front();
                in_valid  <= 1'b1;
                command   <= nxt.cmd;
                address   <= nxt.addr;
                xfer_size <= nxt.size;
                fill_byte <= nxt.fbyte;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: check each taken result against the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        cache_reply_t r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (cache_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"[%0t] result with nothing owed: ",
                                  "kind=%0d hit=%0d data=%h faddr=%h err=%0d"},
                                 $realtime, kind, hit, read_data, fill_address, error);
                end
                else
                begin
                    r = cache_replies.pop_front();
                    if (kind !== r.kind || hit !== r.hit || read_data !== r.data ||
                        fill_address !== r.faddr || error !== r.err)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("[%0t] expected kind=%0d hit=%0d data=%h faddr=%h err=%0d",
                                     $realtime, r.kind, r.hit, r.data, r.faddr, r.err);
                            $display("[%0t]   actual kind=%0d hit=%0d data=%h faddr=%h err=%0d",
                                     $realtime, kind, hit, read_data, fill_address, error);
                        end
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Abandon the run when neither side moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet <= 0;
        end
        else if (quiet == QUIET_LIMIT)
        begin
            $display("[%0t] no handshake for %0d cycles, %0d results still owed",
                     $realtime, QUIET_LIMIT, cache_replies.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. A light mirror of which lines are loaded lets each read that
    // will miss be followed by its full refill, so most traffic is real
    // miss/refill/hit sequences rather than refused reads.
    // ------------------------------------------------------------------
    bit                  gen_ok  [NUM_LINES];
    logic [TAG_BITS-1:0] gen_tag [NUM_LINES];
    logic [TAG_BITS-1:0] tag_pool[3];

    task automatic queue_item(logic cmd, logic [ADDR_BITS-1:0] addr, logic [1:0] size,
                              logic [7:0] fb);
        access_t a;
        a.cmd   = cmd;
        a.addr  = addr;
        a.size  = size;
        a.fbyte = fb;
        access_q.insert(access_q.size(), a);
        n_queued++;
    endtask

    // Mostly a few hot lines and tags so lines get reused and evicted
    function automatic logic [ADDR_BITS-1:0] pick_address(logic [1:0] size, bit straddle);
        int                  len;
        int                  off;
        int                  idx;
        logic [TAG_BITS-1:0] tg;
        len = (size == SIZE_BAD) ? 1 : (1 << size);
        idx = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 7))
                                         : int'($urandom_range(0, NUM_LINES - 1));
        case ($urandom_range(0, 9))
            0:       tg = '0;
            1:       tg = '1;
            2:       tg = TAG_BITS'($urandom);
            default: tg = tag_pool[$urandom_range(0, 2)];
        endcase
        if (straddle)
            off = $urandom_range(LINE_BYTES - len + 1, LINE_BYTES - 1);
        else
            off = $urandom_range(0, LINE_BYTES - len);
        return {tg, IDX_BITS'(idx), OFF_BITS'(off)};
    endfunction

    // Queue a read; on a miss append its refill. A cut below LINE_BYTES drops
    // a stray read into the middle of the refill, which must be refused.
    task automatic queue_read(logic [ADDR_BITS-1:0] addr, logic [1:0] size, int cut);
        int                  off;
        int                  idx;
        logic [TAG_BITS-1:0] tg;
        logic [1:0]          nsz;
        off = int'(addr[OFF_BITS-1:0]);
        idx = int'(addr[OFF_BITS +: IDX_BITS]);
        tg  = addr[ADDR_BITS-1 -: TAG_BITS];
        queue_item(CMD_READ, addr, size, 8'($urandom));
        if (size != SIZE_BAD && off + (1 << size) <= LINE_BYTES &&
            !(gen_ok[idx] && gen_tag[idx] == tg))
        begin
            gen_ok[idx]  = 1'b1;
            gen_tag[idx] = tg;
            for (int i = 0; i < LINE_BYTES; i++)
            begin
                if (i == cut)
                begin
                    nsz = 2'($urandom);
                    queue_item(CMD_READ, pick_address(nsz, 1'b0), nsz, 8'($urandom));
                end
                queue_item(CMD_FILL, $urandom, 2'($urandom), 8'($urandom));
            end
        end
    endtask

    // Hold the sender until the cache owes nothing; sample on the falling
    // edge so the sender's updates of this cycle have settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (access_q.size() != 0 || in_valid || cache_replies.size() != 0);
    endtask

    initial
    begin
        int         idle_tab[4];
        int         stall_tab[4];
        int         pick;
        logic [1:0] sz;
        idle_tab  = '{0, 56, 0, 26};
        stall_tab = '{0, 0, 56, 26};
        foreach (tag_pool[i])
            tag_pool[i] = TAG_BITS'($urandom);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            if (p == 0)
            begin
                // Refill byte with nothing pending: drop silently
                queue_item(CMD_FILL, $urandom, 2'($urandom), 8'($urandom));
                n_queued--;
                // Miss on the top line with all-ones tag; a read lands mid-refill
                queue_read({ADDR_BITS{1'b1}} << OFF_BITS, SIZE_WORD, LINE_BYTES / 2);
                // Hits of every size at the very end of the line
                queue_read({ADDR_BITS{1'b1}}, SIZE_BYTE, LINE_BYTES);
                queue_read({ADDR_BITS{1'b1}} - 1, SIZE_HALF, LINE_BYTES);
                queue_read({ADDR_BITS{1'b1}} - 3, SIZE_WORD, LINE_BYTES);
                // Bad size, then a word straddling the line end
                queue_read({ADDR_BITS{1'b1}} - 12, SIZE_BAD, LINE_BYTES);
                queue_read({ADDR_BITS{1'b1}} - 2, SIZE_WORD, LINE_BYTES);
            end
            while (n_queued < 115 + p * 112)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 72)
                begin
                    sz = 2'($urandom_range(0, 2));
                    queue_read(pick_address(sz, 1'b0), sz,
                               ($urandom_range(0, 9) == 0) ? $urandom_range(1, LINE_BYTES - 1)
                                                           : LINE_BYTES);
                end
                else if (pick < 80)
                begin
                    queue_read(pick_address(SIZE_BAD, 1'b0), SIZE_BAD, LINE_BYTES);
                end
                else if (pick < 90)
                begin
                    sz = 2'($urandom_range(1, 2));
                    queue_read(pick_address(sz, 1'b1), sz, LINE_BYTES);
                end
                else
                begin
                    // Stray refill byte; ignored by the cache, so not counted
                    queue_item(CMD_FILL, $urandom, 2'($urandom), 8'($urandom));
                    n_queued--;
                end
            end
            if (p == 0)
            begin
                repeat (RESET_CYCLES) @(posedge clk);
                rst_n <= 1'b1;
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        mismatches += cache_replies.size();
        $display("Covered %0d reads (%0d hits, %0d misses, %0d refused) and %0d refill bytes",
                 n_reads, n_hits, n_misses, n_refused, n_fill_in);
        $display("completing %0d line refills over four sender/receiver pacing phases",
                 n_refills);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dmc_pkg.sv
rtl/dmc_ram.sv
rtl/direct_mapped_cache_read_top.sv
rtl/dmc_checker.sv
sim/tb_top.sv
